// ===== rtl/rmct_pkg.sv =====
// ----------------------------------------------------------------------------
// rmct_pkg: shared constants and types for the tracked register map
// Operation codes, table sizes and the per-cell request struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rmct_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int RUN_CAP   = 24;
  localparam int RUN_W     = 5;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKING = 1'd1;

  typedef enum logic [3:0] {
    OP_LOAD       = 4'd0,
    OP_SET        = 4'd1,
    OP_WRITE      = 4'd2,
    OP_READ       = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_FIRST_MARK = 4'd5,
    OP_MARK_RUN   = 4'd6,
    OP_PRES_RUN   = 4'd7,
    OP_NEXT_PRES  = 4'd8
  } op_t;

  // what a cell is asked to do each cycle; every cell sees the same request
  typedef struct packed {
    logic              load;     // load this slot index
    logic [IDX_W-1:0]  load_idx;
    logic [ADDR_W-1:0] key;      // address compared against
    logic [DATA_W-1:0] data;
    logic              upd_en;   // apply update to the hit slot
    logic              wr_val;   // store data on hit
    logic              set_mark;
    logic              clr_mark;
  } cell_req_t;

  // result passed along the chain, lowest index first
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [DATA_W-1:0] hit_val;
    logic              hit_mark;
    logic              mk;       // first marked seen
    logic [ADDR_W-1:0] mk_addr;
    logic              nx;       // smallest address above key seen
    logic [ADDR_W-1:0] nx_addr;
  } chain_t;

endpackage

`default_nettype wire

// ===== rtl/rmct_cell.sv =====
// ----------------------------------------------------------------------------
// rmct_cell: one table slot
// Holds address, value and mark; folds its own compare into the chain word
// arriving from the lower-index neighbour and registers it for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmct_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [rmct_pkg::IDX_W-1:0] my_idx,
  input  wire logic                      in_use,
  input  wire rmct_pkg::cell_req_t       req,
  input  wire rmct_pkg::chain_t          chain_in,
  output rmct_pkg::chain_t               chain_out
);
  import rmct_pkg::*;

  logic [ADDR_W-1:0] slot_address;
  logic [DATA_W-1:0] slot_value;
  logic              slot_marked;
  logic              match;
  logic              upd_hit;
  chain_t            chain_next;

  assign match   = in_use && (slot_address == req.key);
  // updates are steered by the winning index found on the previous pass
  assign upd_hit = req.upd_en && in_use && (req.key == slot_address)
                   && (chain_in.hit_idx == my_idx) && chain_in.hit;

  always_comb begin
    chain_next = chain_in;
    if (match && !chain_in.hit) begin
      chain_next.hit      = 1'b1;
      chain_next.hit_idx  = my_idx;
      chain_next.hit_val  = slot_value;
      chain_next.hit_mark = slot_marked;
    end
    if (in_use && slot_marked && !chain_in.mk) begin
      chain_next.mk      = 1'b1;
      chain_next.mk_addr = slot_address;
    end
    if (in_use && slot_address > req.key
        && (!chain_in.nx || slot_address < chain_in.nx_addr)) begin
      chain_next.nx      = 1'b1;
      chain_next.nx_addr = slot_address;
    end
  end

  always_ff @(posedge clk) begin
    chain_out <= chain_next;
    if (req.load && req.load_idx == my_idx) begin
      slot_address <= req.key;
      slot_value   <= req.data;
    end else if (upd_hit && req.wr_val) begin
      slot_value <= req.data;
    end
    if (rst) begin
      slot_marked <= 1'b0;
    end else if (req.load && req.load_idx == my_idx) begin
      slot_marked <= 1'b0;
    end else if (upd_hit && req.set_mark) begin
      slot_marked <= 1'b1;
    end else if (upd_hit && req.clr_mark) begin
      slot_marked <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rmct_chain.sv =====
// ----------------------------------------------------------------------------
// rmct_chain: row of slot cells
// The chain word ripples one cell per cycle; the tail result is valid
// once the word has passed every cell, the request being held meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module rmct_chain (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [rmct_pkg::CNT_W-1:0] active,
  input  wire rmct_pkg::cell_req_t       req,
  output rmct_pkg::chain_t               result
);
  import rmct_pkg::*;

  chain_t links [ENTRIES+1];
  chain_t hit_hint;

  // a tail word from the previous search tells cells which index won
  always_comb begin
    links[0]         = '0;
    links[0].hit     = hit_hint.hit;
    links[0].hit_idx = hit_hint.hit_idx;
  end

  // in an update every cell takes the hint directly, not from its neighbour
  assign hit_hint = req.upd_en ? result : '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    chain_t cin;
    always_comb begin
      cin = links[g];
      if (!req.upd_en && g == 0) cin = '0;
    end
    rmct_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_idx   (IDX_W'(g)),
      .in_use   (CNT_W'(g) < active),
      .req      (req),
      .chain_in (req.upd_en ? links[0] : cin),
      .chain_out(links[g+1])
    );
  end

  assign result = links[ENTRIES];

endmodule

`default_nettype wire

// ===== rtl/register_map_with_change_tracking.sv =====
// ----------------------------------------------------------------------------
// register_map_with_change_tracking: tracked register table
// Use: present an item on in_valid/in_ready; one result item follows on
// out_valid/out_ready. Lookups ripple through a row of 64 slot cells, one
// cell per cycle; a lookup pass ripples the word through every cell, then
// picks up the tail word. Per item:
//   load_entry          : a load step
//   read, first_marked,
//   next_present        : one pass
//   set/write/clear     : one pass, then an update step on a hit
//   runs                : one pass per address looked at, up to 25 passes
// One item is in work at a time. The result sits in an output register;
// in_ready rises again only once it is taken, so a stalled receiver holds
// the block. Reset clears all marks, sets entries_in_use to 0 and
// tracking_enable to 1; slot addresses and values are undefined until
// loaded. Configuration writes land at once on cfg_we.
// ----------------------------------------------------------------------------
`default_nettype none

module register_map_with_change_tracking (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rmct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rmct_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [3:0]                     operation,
  input  wire logic [rmct_pkg::IDX_W-1:0]     entry_index,
  input  wire logic [rmct_pkg::ADDR_W-1:0]    address,
  input  wire logic [rmct_pkg::DATA_W-1:0]    value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                found,
  output logic [rmct_pkg::ADDR_W-1:0]         address_out,
  output logic [rmct_pkg::DATA_W-1:0]         value_out,
  output logic [rmct_pkg::RUN_W-1:0]          run_length
);
  import rmct_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_PASS, S_UPD, S_DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  entries_in_use;
  logic              tracking_enable;
  logic [CNT_W-1:0]  active;
  logic [3:0]        op;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] key;
  logic [DATA_W-1:0] data;
  logic [CNT_W-1:0]  wait_cnt;
  logic [RUN_W-1:0]  run_cnt;
  logic              run_first;
  cell_req_t         req;
  chain_t            res;

  assign active = (entries_in_use > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : entries_in_use;

  always_comb begin
    req          = '0;
    req.key      = key;
    req.data     = data;
    req.load_idx = idx;
    req.load     = (state == S_LOAD);
    if (state == S_UPD) begin
      req.upd_en = 1'b1;
      unique case (op)
        OP_SET: begin
          req.wr_val   = res.hit_val != data;
          req.set_mark = (res.hit_val != data) && tracking_enable;
        end
        OP_WRITE: req.wr_val   = 1'b1;
        OP_CLEAR: req.clr_mark = 1'b1;
        default: ;
      endcase
    end
  end

  rmct_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .active(active),
    .req   (req),
    .result(res)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      entries_in_use  <= '0;
      tracking_enable <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENTRIES:  entries_in_use  <= cfg_data;
          REG_TRACKING: tracking_enable <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= operation;
            idx         <= entry_index;
            key         <= address;
            data        <= value;
            wait_cnt    <= '0;
            run_cnt     <= RUN_W'(1);
            run_first   <= 1'b1;
            found       <= 1'b0;
            address_out <= '0;
            value_out   <= '0;
            run_length  <= '0;
            if (operation == OP_LOAD) begin
              state <= S_LOAD;
            end else if (operation > OP_NEXT_PRES) begin
              state     <= S_DONE;
              out_valid <= 1'b1;
            end else begin
              state <= S_PASS;
            end
          end
        end
        S_LOAD: begin
          found     <= 1'b1;
          state     <= S_DONE;
          out_valid <= 1'b1;
        end
        S_PASS: begin
          if (wait_cnt == CNT_W'(ENTRIES)) begin
            wait_cnt <= '0;
            unique case (op)
              OP_SET, OP_WRITE, OP_CLEAR: begin
                found <= res.hit;
                if (res.hit) state <= S_UPD;
                else begin state <= S_DONE; out_valid <= 1'b1; end
              end
              OP_READ: begin
                found     <= res.hit;
                value_out <= res.hit ? res.hit_val : '0;
                state     <= S_DONE;
                out_valid <= 1'b1;
              end
              OP_FIRST_MARK: begin
                found       <= res.mk;
                address_out <= res.mk ? res.mk_addr : '0;
                state       <= S_DONE;
                out_valid   <= 1'b1;
              end
              OP_NEXT_PRES: begin
                found       <= res.nx;
                address_out <= res.nx ? res.nx_addr : '0;
                state       <= S_DONE;
                out_valid   <= 1'b1;
              end
              default: begin
                // run: first pass looks up the start, then each next address
                if (run_first) begin
                  run_first <= 1'b0;
                  found     <= res.hit;
                end else if (res.hit && (op == OP_PRES_RUN || res.hit_mark)) begin
                  run_cnt <= run_cnt + 1'b1;
                end
                if (!run_first && !(res.hit && (op == OP_PRES_RUN || res.hit_mark))) begin
                  run_length <= run_cnt;
                  state      <= S_DONE;
                  out_valid  <= 1'b1;
                end else if ((!run_first && run_cnt == RUN_W'(RUN_CAP))
                             || key == '1) begin
                  run_length <= run_first ? run_cnt : run_cnt + 1'b1;
                  state      <= S_DONE;
                  out_valid  <= 1'b1;
                end else begin
                  key <= key + 1'b1;
                end
              end
            endcase
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        S_UPD: begin
          state     <= S_DONE;
          out_valid <= 1'b1;
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_DONE) else $error("result shown outside done");
  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length <= RUN_W'(RUN_CAP + 1)) else $error("run too long");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("accept while busy");

endmodule

`default_nettype wire

// ===== bench/tb_register_map_with_change_tracking.sv =====
// ----------------------------------------------------------------------------
// tb_register_map_with_change_tracking: self-checking bench for the tracked map
// Drives table operations over valid/ready with random gaps and stalls, keeps
// its own copy of the table, and compares every result item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_register_map_with_change_tracking;
  timeunit 1ns;
  timeprecision 1ps;
  import rmct_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int N_PHASES   = 7;
  localparam int PHASE_ITEMS = 96;

  typedef struct {
    logic              found;
    logic [ADDR_W-1:0] address_out;
    logic [DATA_W-1:0] value_out;
    logic [RUN_W-1:0]  run_length;
  } result_t;

  typedef struct {
    logic [3:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] val;
    bit                typed;
    result_t           res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] operation = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic [ADDR_W-1:0] address = '0;
  logic [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [ADDR_W-1:0] address_out;
  logic [DATA_W-1:0] value_out;
  logic [RUN_W-1:0] run_length;

  always #5 clk = ~clk;

  register_map_with_change_tracking i_dut (.*);

  // shadow copy of the table
  logic [ADDR_W-1:0] tbl_addr [ENTRIES];
  logic [DATA_W-1:0] tbl_val [ENTRIES];
  bit                tbl_mark [ENTRIES];
  logic [CNT_W-1:0]  in_use = '0;
  bit                tracking = 1'b1;

  result_t pending_results[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  bit      no_idle = 1'b0;
  logic [ADDR_W-1:0] addr_base;

  function automatic int active_slots();
    return (in_use > ENTRIES) ? ENTRIES : int'(in_use);
  endfunction

  function automatic int find_slot(int unsigned a);
    for (int i = 0; i < active_slots(); i++)
      if (tbl_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int unsigned count_run(int unsigned start, bit need_mark);
    int unsigned cnt = 1;
    int unsigned a = start;
    int k;
    while (cnt <= RUN_CAP) begin
      if (a >= 16'hFFFF) break;
      a++;
      k = find_slot(a);
      if (k < 0) break;
      if (need_mark && !tbl_mark[k]) break;
      cnt++;
    end
    return cnt;
  endfunction

  function automatic result_t apply_item(logic [3:0] op, logic [IDX_W-1:0] idx,
                                         logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    result_t r = '{default: '0};
    int k;
    case (op)
      OP_LOAD: begin
        tbl_addr[idx] = addr;
        tbl_val[idx] = val;
        tbl_mark[idx] = 1'b0;
        r.found = 1'b1;
      end
      OP_SET: begin
        k = find_slot(addr);
        if (k >= 0) begin
          r.found = 1'b1;
          if (tbl_val[k] != val) begin
            if (tracking) tbl_mark[k] = 1'b1;
            tbl_val[k] = val;
          end
        end
      end
      OP_WRITE: begin
        k = find_slot(addr);
        if (k >= 0) begin
          r.found = 1'b1;
          tbl_val[k] = val;
        end
      end
      OP_READ: begin
        k = find_slot(addr);
        if (k >= 0) begin
          r.found = 1'b1;
          r.value_out = tbl_val[k];
        end
      end
      OP_CLEAR: begin
        k = find_slot(addr);
        if (k >= 0) begin
          r.found = 1'b1;
          tbl_mark[k] = 1'b0;
        end
      end
      OP_FIRST_MARK: begin
        for (int i = 0; i < active_slots(); i++)
          if (tbl_mark[i]) begin
            r.found = 1'b1;
            r.address_out = tbl_addr[i];
            break;
          end
      end
      OP_MARK_RUN, OP_PRES_RUN: begin
        r.found = find_slot(addr) >= 0;
        r.run_length = RUN_W'(count_run(addr, op == OP_MARK_RUN));
      end
      OP_NEXT_PRES: begin
        for (int i = 0; i < active_slots(); i++)
          if (tbl_addr[i] > addr && (!r.found || tbl_addr[i] < r.address_out)) begin
            r.found = 1'b1;
            r.address_out = tbl_addr[i];
          end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [3:0] op, logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] val, bit typed, result_t typed_res);
    int gap;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    entry_index = idx;
    address = addr;
    value = val;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = apply_item(op, idx, addr, val);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ENTRIES) in_use = data;
    else tracking = data[0];
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r = $urandom_range(0, 9);
    if (r < 7) return addr_base + ADDR_W'($urandom_range(0, 40));
    if (r < 9) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_val();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_op();
    int r = $urandom_range(0, 99);
    if (r < 10) return OP_LOAD;
    if (r < 30) return OP_SET;
    if (r < 40) return OP_WRITE;
    if (r < 55) return OP_READ;
    if (r < 65) return OP_CLEAR;
    if (r < 73) return OP_FIRST_MARK;
    if (r < 83) return OP_MARK_RUN;
    if (r < 91) return OP_PRES_RUN;
    if (r < 98) return OP_NEXT_PRES;
    return 4'($urandom_range(9, 15));
  endfunction

  // result side: random stall before each item
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0h actual %0h", want.found, found);
          fail_count++;
        end
        if (address_out !== want.address_out) begin
          $error("address_out: expected %0h actual %0h", want.address_out, address_out);
          fail_count++;
        end
        if (value_out !== want.value_out) begin
          $error("value_out: expected %0h actual %0h", want.value_out, value_out);
          fail_count++;
        end
        if (run_length !== want.run_length) begin
          $error("run_length: expected %0d actual %0d", want.run_length, run_length);
          fail_count++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("register_map_with_change_tracking verification failed");
      $finish;
    end
  end

  // nothing in use after reset: every lookup misses, runs stop at one
  row_t directed[] = '{
    '{OP_READ,       6'd0,  16'h1234, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_FIRST_MARK, 6'd0,  16'h0000, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_NEXT_PRES,  6'd0,  16'h0000, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_NEXT_PRES,  6'd0,  16'hFFFF, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_PRES_RUN,   6'd0,  16'hFFFF, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd1}},
    '{OP_MARK_RUN,   6'd0,  16'h0000, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd1}},
    '{OP_SET,        6'd0,  16'hFFFF, 16'hFFFF, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_WRITE,      6'd0,  16'h0000, 16'hFFFF, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_CLEAR,      6'd0,  16'h8000, 16'h0000, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{4'd9,          6'd63, 16'hFFFF, 16'hFFFF, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{4'd15,         6'd63, 16'hFFFF, 16'hFFFF, 1, '{1'b0, 16'h0, 16'h0, 5'd0}},
    '{OP_LOAD,       6'd0,  16'hFFFF, 16'hFFFF, 1, '{1'b1, 16'h0, 16'h0, 5'd0}},
    '{OP_LOAD,       6'd63, 16'h0000, 16'h0000, 1, '{1'b1, 16'h0, 16'h0, 5'd0}}
  };

  logic [CNT_W-1:0] phase_entries [N_PHASES] = '{7'd64, 7'd127, 7'd10, 7'd1, 7'd0, 7'd40, 7'd64};
  bit phase_tracking [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  logic [ADDR_W-1:0] phase_base [N_PHASES] = '{16'h0000, 16'hFFE0, 16'h1200, 16'h0000,
                                             16'h4000, 16'hFFF0, 16'h7FF0};

  initial begin
    logic [3:0] op;
    for (int i = 0; i < ENTRIES; i++) tbl_mark[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_reg(REG_ENTRIES, 7'd0);
    write_reg(REG_TRACKING, 7'h7F);
    foreach (directed[i])
      send_item(directed[i].op, directed[i].idx, directed[i].addr, directed[i].val,
                directed[i].typed, directed[i].res);
    // fill every slot before any lookup can see it
    for (int i = 0; i < ENTRIES; i++)
      send_item(OP_LOAD, IDX_W'(i), 16'h0000 + ADDR_W'(i), pick_val(), 0, '{default: '0});
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_ENTRIES, phase_entries[p]);
      write_reg(REG_TRACKING, {6'($urandom), phase_tracking[p]});
      addr_base = phase_base[p];
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_op();
        if (op == OP_LOAD && $urandom_range(0, 1))
          send_item(op, IDX_W'($urandom), addr_base + ADDR_W'($urandom_range(0, 30)),
                    pick_val(), 0, '{default: '0});
        else
          send_item(op, IDX_W'($urandom), pick_addr(), pick_val(), 0, '{default: '0});
      end
    end
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (pending_results.size() != 0) fail_count++;
    $display("Covered %0d items and %0d results over %0d configurations,", items_sent,
             results_seen, N_PHASES + 1);
    $display("including full, oversized, single and empty tables with tracking on and off.");
    if (fail_count == 0) begin
      $display("register_map_with_change_tracking verification clean");
    end else begin
      $display("register_map_with_change_tracking verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
